// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers; define NO_ASSERTIONS to compile them out.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// clocked check, masked while reset is high
`define MNPS_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked check, live during reset as well
`define MNPS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define MNPS_ASSERT(lbl, clk, rst, prop, msg)
`define MNPS_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

// ===== rtl/mnps_pkg.sv =====
// ----------------------------------------------------------------------------
// mnps_pkg
// Shared types and codes for the held-note stack.
// ----------------------------------------------------------------------------
`default_nettype none

package mnps_pkg;

   localparam int NOTE_W    = 7;
   localparam int VEL_W     = 7;
   localparam int REQ_TDATA_W = 24;
   localparam int RSP_TDATA_W = 24;

   // opcodes
   localparam logic [2:0] OP_NOTE_ON       = 3'd0;
   localparam logic [2:0] OP_NOTE_OFF      = 3'd1;
   localparam logic [2:0] OP_LATCH_RELEASE = 3'd2;
   localparam logic [2:0] OP_CLEAR_LATCHED = 3'd3;
   localparam logic [2:0] OP_SORT          = 3'd4;
   localparam logic [2:0] OP_CLEAR         = 3'd5;
   localparam logic [2:0] OP_READ          = 3'd6;

   // pass modes of the sweep unit
   localparam logic [2:0] MODE_MATCH_ALL  = 3'd0; // drop every entry with the key note
   localparam logic [2:0] MODE_FLAG       = 3'd1; // drop every released entry
   localparam logic [2:0] MODE_FIRST_NOTE = 3'd2; // drop oldest entry with the key note
   localparam logic [2:0] MODE_FIRST_ANY  = 3'd3; // drop oldest entry
   localparam logic [2:0] MODE_LATCH      = 3'd4; // mark oldest entry with the key note
   localparam logic [2:0] MODE_SORT       = 3'd5; // one bubble pass, ascending note

   typedef struct packed {
      logic [NOTE_W-1:0] note;
      logic [VEL_W-1:0]  velocity;
      logic              released;
   } entry_type;

   typedef struct packed {
      logic      wr_en;
      entry_type wr_data;
      logic      hit;
      logic      carry_load;
      logic      swap;
   } pass_type;

endpackage

`default_nettype wire

// ===== rtl/mnps_pass_unit.sv =====
// ----------------------------------------------------------------------------
// mnps_pass_unit
// Per-entry decision of a sweep: keep, drop, mark or bubble-swap.
// ----------------------------------------------------------------------------
`default_nettype none

module mnps_pass_unit (
   input  wire logic [2:0]                mode,
   input  wire mnps_pkg::entry_type       entry,
   input  wire logic [mnps_pkg::NOTE_W-1:0] key_note,
   input  wire logic                      hit,
   input  wire mnps_pkg::entry_type       carry,
   input  wire logic                      have_carry,
   output mnps_pkg::pass_type             pass
);

   logic match;
   logic first;

   assign match = (entry.note == key_note);
   assign first = match && !hit;

   always_comb begin
      pass            = '0;
      pass.wr_data    = entry;
      pass.hit        = hit;
      unique case (mode)
         mnps_pkg::MODE_MATCH_ALL: begin
            pass.wr_en = !match;
         end
         mnps_pkg::MODE_FLAG: begin
            pass.wr_en = !entry.released;
         end
         mnps_pkg::MODE_FIRST_NOTE: begin
            pass.wr_en = !first;
            pass.hit   = hit | match;
         end
         mnps_pkg::MODE_FIRST_ANY: begin
            pass.wr_en = hit;
            pass.hit   = 1'b1;
         end
         mnps_pkg::MODE_LATCH: begin
            pass.wr_en            = 1'b1;
            pass.wr_data.released = entry.released | first;
            pass.hit              = hit | match;
         end
         mnps_pkg::MODE_SORT: begin
            if (!have_carry) begin
               pass.carry_load = 1'b1;
            end else if (carry.note > entry.note) begin
               // smaller note overtakes the carried one
               pass.wr_en = 1'b1;
               pass.swap  = 1'b1;
            end else begin
               pass.wr_en      = 1'b1;
               pass.wr_data    = carry;
               pass.carry_load = 1'b1;
            end
         end
         default: begin
            pass.wr_en = 1'b1;
         end
      endcase
   end

endmodule

`default_nettype wire

// ===== rtl/midi_note_priority_stack.sv =====
// ----------------------------------------------------------------------------
// midi_note_priority_stack
// Ordered stack of held MIDI notes, oldest first, with sweep-based editing.
// ----------------------------------------------------------------------------
// req_: one transaction per operation; req_tready is high only while the
//   sequencer is idle, so one operation is worked at a time.
// rsp_: one transaction per operation, in order: the read entry (zero unless
//   a read), the entry count and an empty flag.
// Editing is a sweep through the registered-read entry memory by one shared
//   compare unit, one entry per cycle, kept entries written back compacted.
// Clear, unused opcodes and a read of an empty stack go straight to the
//   result; a read first waits for the registered memory read. Note off,
//   latch release and clear latched are one sweep; note on is a sweep
//   that drops any entry with the same note, then an append, with a sweep
//   dropping the oldest entry between them when full with no match; sort
//   repeats bubble passes until one swaps nothing, up to N (N = entries held).
// A result waits in the output register while rsp_tready is low; the next
//   request is still accepted and its result is held until the register frees.
// reset (synchronous, active high) empties the stack and drops any pending
//   result; memory is not cleared, only positions below the count are read.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module midi_note_priority_stack #(
   parameter int STACK_DEPTH = 16
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   // req_tdata, low bit up: opcode[2:0], note_number[9:3],
   // note_velocity[16:10], latched_on[17], read_index[21:18], zero pad
   input  wire logic                               req_tvalid,
   output logic                                    req_tready,
   input  wire logic [mnps_pkg::REQ_TDATA_W-1:0]   req_tdata,
   // rsp_tdata, low bit up: out_note[6:0], out_velocity[13:7],
   // out_released[14], entry_count[19:15], read_empty[20], zero pad
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   output logic [mnps_pkg::RSP_TDATA_W-1:0]        rsp_tdata
);

   localparam int CNT_W = $clog2(STACK_DEPTH + 1);
   localparam int IDX_W = $clog2(STACK_DEPTH);
   localparam int CMP_W = (CNT_W > 4) ? CNT_W : 4;

   // sequencer states
   localparam logic [2:0] S_IDLE    = 3'd0;
   localparam logic [2:0] S_SCAN    = 3'd1;
   localparam logic [2:0] S_APPEND  = 3'd2;
   localparam logic [2:0] S_RD_WAIT = 3'd3;
   localparam logic [2:0] S_FIN     = 3'd4;

   // request fields
   logic [2:0]                  req_opcode;
   logic [mnps_pkg::NOTE_W-1:0] req_note;
   logic [mnps_pkg::VEL_W-1:0]  req_velocity;
   logic                        req_latched;
   logic [3:0]                  req_index;
   logic                        req_accept;

   assign req_opcode   = req_tdata[2:0];
   assign req_note     = req_tdata[9:3];
   assign req_velocity = req_tdata[16:10];
   assign req_latched  = req_tdata[17];
   assign req_index    = req_tdata[21:18];
   assign req_accept   = req_tvalid && req_tready;

   // control state
   logic [2:0]       state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             vld_ff, vld_in;
   logic             rsp_valid_ff, rsp_valid_in;

   // sweep and payload state
   logic [2:0]                    mode_ff, mode_in;
   logic [CNT_W-1:0]              rd_ff, rd_in;
   logic [CNT_W-1:0]              wr_ff, wr_in;
   logic                          hit_ff, hit_in;
   logic                          have_ff, have_in;
   logic                          swap_ff, swap_in;
   mnps_pkg::entry_type           carry_ff, carry_in;
   logic [mnps_pkg::NOTE_W-1:0]   key_ff, key_in;
   logic [mnps_pkg::VEL_W-1:0]    vel_ff, vel_in;
   logic                          lat_ff, lat_in;
   mnps_pkg::entry_type           res_ff, res_in;
   logic                          empty_ff, empty_in;
   logic [mnps_pkg::RSP_TDATA_W-1:0] rsp_data_ff, rsp_data_in;

   // entry memory
   mnps_pkg::entry_type mem [STACK_DEPTH];
   mnps_pkg::entry_type rdata_ff;
   logic                mem_we;
   logic [IDX_W-1:0]    waddr;
   logic [IDX_W-1:0]    raddr;
   mnps_pkg::entry_type wdata;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   // shared compare unit
   mnps_pkg::pass_type pass;

   mnps_pass_unit u_pass (
      .mode       (mode_ff),
      .entry      (rdata_ff),
      .key_note   (key_ff),
      .hit        (hit_ff),
      .carry      (carry_ff),
      .have_carry (have_ff),
      .pass       (pass)
   );

   // read position, clamped to the last entry
   logic [CMP_W-1:0] idx_ext;
   logic [CMP_W-1:0] cnt_ext;
   logic [CMP_W-1:0] rd_pos;

   assign idx_ext = CMP_W'(req_index);
   assign cnt_ext = CMP_W'(cnt_ff);
   assign rd_pos  = (idx_ext < cnt_ext) ? idx_ext : (cnt_ext - CMP_W'(1));

   // count reported masked to five bits
   logic [CNT_W+4:0] cnt_wide;
   assign cnt_wide = {5'b00000, cnt_ff};

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      vld_in       = vld_ff;
      rsp_valid_in = rsp_valid_ff;
      mode_in      = mode_ff;
      rd_in        = rd_ff;
      wr_in        = wr_ff;
      hit_in       = hit_ff;
      have_in      = have_ff;
      swap_in      = swap_ff;
      carry_in     = carry_ff;
      key_in       = key_ff;
      vel_in       = vel_ff;
      lat_in       = lat_ff;
      res_in       = res_ff;
      empty_in     = empty_ff;
      rsp_data_in  = rsp_data_ff;
      mem_we       = 1'b0;
      waddr        = wr_ff[IDX_W-1:0];
      wdata        = pass.wr_data;
      raddr        = rd_ff[IDX_W-1:0];

      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               key_in   = req_note;
               vel_in   = req_velocity;
               lat_in   = req_latched;
               res_in   = '0;
               empty_in = 1'b0;
               rd_in    = '0;
               wr_in    = '0;
               vld_in   = 1'b0;
               hit_in   = 1'b0;
               have_in  = 1'b0;
               swap_in  = 1'b0;
               unique case (req_opcode)
                  mnps_pkg::OP_NOTE_ON: begin
                     mode_in  = mnps_pkg::MODE_MATCH_ALL;
                     state_in = S_SCAN;
                  end
                  mnps_pkg::OP_NOTE_OFF: begin
                     mode_in  = mnps_pkg::MODE_FIRST_NOTE;
                     state_in = S_SCAN;
                  end
                  mnps_pkg::OP_LATCH_RELEASE: begin
                     mode_in  = mnps_pkg::MODE_LATCH;
                     state_in = S_SCAN;
                  end
                  mnps_pkg::OP_CLEAR_LATCHED: begin
                     mode_in  = mnps_pkg::MODE_FLAG;
                     state_in = S_SCAN;
                  end
                  mnps_pkg::OP_SORT: begin
                     mode_in  = mnps_pkg::MODE_SORT;
                     state_in = S_SCAN;
                  end
                  mnps_pkg::OP_CLEAR: begin
                     cnt_in   = '0;
                     state_in = S_FIN;
                  end
                  mnps_pkg::OP_READ: begin
                     if (cnt_ff == '0) begin
                        empty_in = 1'b1;
                        state_in = S_FIN;
                     end else begin
                        raddr    = rd_pos[IDX_W-1:0];
                        state_in = S_RD_WAIT;
                     end
                  end
                  default: begin
                     state_in = S_FIN;
                  end
               endcase
            end
         end

         S_SCAN: begin
            // issue side: one read a cycle until the count is reached
            if (rd_ff != cnt_ff) begin
               rd_in  = rd_ff + CNT_W'(1);
               vld_in = 1'b1;
            end else begin
               vld_in = 1'b0;
            end

            if (vld_ff) begin
               // decision side: entry read last cycle
               mem_we = pass.wr_en;
               if (pass.wr_en) begin
                  wr_in = wr_ff + CNT_W'(1);
               end
               hit_in = pass.hit;
               if (pass.carry_load) begin
                  carry_in = rdata_ff;
               end
               if (mode_ff == mnps_pkg::MODE_SORT) begin
                  have_in = 1'b1;
               end
               if (pass.swap) begin
                  swap_in = 1'b1;
               end
            end else if (rd_ff == cnt_ff) begin
               // end of sweep
               unique case (mode_ff)
                  mnps_pkg::MODE_MATCH_ALL: begin
                     cnt_in = wr_ff;
                     if (wr_ff == CNT_W'(STACK_DEPTH)) begin
                        // full with no match: drop the oldest first
                        mode_in = mnps_pkg::MODE_FIRST_ANY;
                        rd_in   = '0;
                        wr_in   = '0;
                        hit_in  = 1'b0;
                     end else begin
                        state_in = S_APPEND;
                     end
                  end
                  mnps_pkg::MODE_FIRST_ANY: begin
                     cnt_in   = wr_ff;
                     state_in = S_APPEND;
                  end
                  mnps_pkg::MODE_FIRST_NOTE,
                  mnps_pkg::MODE_FLAG: begin
                     cnt_in   = wr_ff;
                     state_in = S_FIN;
                  end
                  mnps_pkg::MODE_SORT: begin
                     if (have_ff) begin
                        mem_we = 1'b1;
                        wdata  = carry_ff;
                     end
                     if (swap_ff) begin
                        rd_in   = '0;
                        wr_in   = '0;
                        have_in = 1'b0;
                        swap_in = 1'b0;
                     end else begin
                        state_in = S_FIN;
                     end
                  end
                  default: begin
                     state_in = S_FIN;
                  end
               endcase
            end
         end

         S_APPEND: begin
            mem_we   = 1'b1;
            waddr    = cnt_ff[IDX_W-1:0];
            wdata    = '{note: key_ff, velocity: vel_ff, released: lat_ff};
            cnt_in   = cnt_ff + CNT_W'(1);
            state_in = S_FIN;
         end

         S_RD_WAIT: begin
            res_in   = rdata_ff;
            state_in = S_FIN;
         end

         S_FIN: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {3'b000, empty_ff, cnt_wide[4:0], res_ff.released,
                               res_ff.velocity, res_ff.note};
               state_in     = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         vld_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         vld_ff       <= vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff     <= mode_in;
      rd_ff       <= rd_in;
      wr_ff       <= wr_in;
      hit_ff      <= hit_in;
      have_ff     <= have_in;
      swap_ff     <= swap_in;
      carry_ff    <= carry_in;
      key_ff      <= key_in;
      vel_ff      <= vel_in;
      lat_ff      <= lat_in;
      res_ff      <= res_in;
      empty_ff    <= empty_in;
      rsp_data_ff <= rsp_data_in;
   end

   // checks
   `MNPS_ASSERT(a_cnt_bound, clock, reset, cnt_ff <= CNT_W'(STACK_DEPTH), "count above depth")
   `MNPS_ASSERT(a_wr_behind, clock, reset, (state_ff == S_SCAN) |-> (wr_ff <= rd_ff), "write ahead")
   `MNPS_ASSERT(a_rsp_from_fin, clock, reset, $rose(rsp_valid_ff) |-> ($past(state_ff) == S_FIN), "early result")
   `MNPS_ASSERT(a_busy_after_accept, clock, reset, req_accept |=> (state_ff != S_IDLE), "idle after accept")

endmodule

`default_nettype wire
